[design/pngrs_pkg.sv]
// Package: shared widths, header codes and Adam7 pass tables for the PNG raw size block.
`default_nettype none

package pngrs_pkg;

  // Field widths fixed by the header format and the result format
  localparam int FIELD_W    = 8;
  localparam int BPP_W      = 7;
  localparam int RAW_W      = 52;
  localparam int NUM_PASSES = 7;
  localparam int NUM_STAGES = 7;

  // Color type codes
  localparam logic [FIELD_W-1:0] CT_GRAY       = 8'd0;
  localparam logic [FIELD_W-1:0] CT_RGB        = 8'd2;
  localparam logic [FIELD_W-1:0] CT_INDEXED    = 8'd3;
  localparam logic [FIELD_W-1:0] CT_GRAY_ALPHA = 8'd4;
  localparam logic [FIELD_W-1:0] CT_RGBA       = 8'd6;

  // Method codes
  localparam logic [FIELD_W-1:0] COMP_DEFLATE    = 8'd0;
  localparam logic [FIELD_W-1:0] FILT_ADAPTIVE   = 8'd0;
  localparam logic [FIELD_W-1:0] ILACE_NONE      = 8'd0;
  localparam logic [FIELD_W-1:0] ILACE_ADAM7     = 8'd1;

  // Bit depth codes
  localparam logic [FIELD_W-1:0] DEPTH_1  = 8'd1;
  localparam logic [FIELD_W-1:0] DEPTH_2  = 8'd2;
  localparam logic [FIELD_W-1:0] DEPTH_4  = 8'd4;
  localparam logic [FIELD_W-1:0] DEPTH_8  = 8'd8;
  localparam logic [FIELD_W-1:0] DEPTH_16 = 8'd16;

  typedef logic [3:0] nib_t;

  // Per pass: entry 0 is the count per full block of 8, entry r the count for remainder r
  localparam nib_t ROW_TAB [NUM_PASSES][8] = '{
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1},
    '{4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2},
    '{4'd2, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2},
    '{4'd4, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4},
    '{4'd4, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3}
  };

  localparam nib_t COL_TAB [NUM_PASSES][8] = '{
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1},
    '{4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2},
    '{4'd2, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2},
    '{4'd4, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4},
    '{4'd4, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3},
    '{4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7}
  };

endpackage

`default_nettype wire

[design/png_raw_image_size_top.sv]
// PNG header checker and raw image data size, seven-stage pipeline.
// Throughput: one header per cycle unless all stages are full and the
// output stalls; each stage holds one beat and the stages collapse
// bubbles, so input is taken while the output waits if a stage is empty.
// Reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none

module png_raw_image_size_top #(
  parameter int IMAGE_DIM_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [IMAGE_DIM_BITS-1:0]               width_i,
  input  logic [IMAGE_DIM_BITS-1:0]               height_i,
  input  logic [pngrs_pkg::FIELD_W-1:0]           bit_depth_i,
  input  logic [pngrs_pkg::FIELD_W-1:0]           color_type_i,
  input  logic [pngrs_pkg::FIELD_W-1:0]           compression_method_i,
  input  logic [pngrs_pkg::FIELD_W-1:0]           filter_method_i,
  input  logic [pngrs_pkg::FIELD_W-1:0]           interlace_method_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    header_ok_o,
  output logic [pngrs_pkg::BPP_W-1:0]             bits_per_pixel_o,
  output logic [pngrs_pkg::RAW_W-1:0]             raw_bytes_o
);

  import pngrs_pkg::*;

  localparam int DIM_W  = IMAGE_DIM_BITS;
  localparam int PROD_W = DIM_W + 6;       // pixels times at most 64 bits
  localparam int RB_W   = DIM_W + 3;       // row bytes with filter byte
  localparam int LO_W   = RB_W / 2;
  localparam int HI_W   = RB_W - LO_W;
  localparam int PLO_W  = DIM_W + LO_W;
  localparam int PHI_W  = DIM_W + HI_W;
  localparam int TERM_W = DIM_W + RB_W;

  // Stage control
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] rdy;
  logic                  ok_q  [NUM_STAGES];
  logic [BPP_W-1:0]      bpp_q [NUM_STAGES];

  // Stage payloads
  logic [DIM_W-1:0]  lines_s1_q [NUM_PASSES];
  logic [DIM_W-1:0]  pix_s1_q   [NUM_PASSES];
  logic [DIM_W-1:0]  lines_s2_q [NUM_PASSES];
  logic [PROD_W-1:0] prod_s2_q  [NUM_PASSES];
  logic [DIM_W-1:0]  lines_s3_q [NUM_PASSES];
  logic [RB_W-1:0]   rb_s3_q    [NUM_PASSES];
  logic [PLO_W-1:0]  plo_s4_q   [NUM_PASSES];
  logic [PHI_W-1:0]  phi_s4_q   [NUM_PASSES];
  logic [RAW_W-1:0]  term_s5_q  [NUM_PASSES];
  logic [RAW_W-1:0]  part_s6_q  [4];
  logic [RAW_W-1:0]  raw_s7_q;

  // Decode results
  logic              ok_d;
  logic [BPP_W-1:0]  bpp_d;
  logic [DIM_W-1:0]  lines_d [NUM_PASSES];
  logic [DIM_W-1:0]  pix_d   [NUM_PASSES];

  // Ready chain: a stage loads when empty or when the next one moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  // Check the header, pick the bits per pixel and the pass dimensions
  always_comb begin
    logic             low_d;
    logic             hi_d;
    logic [2:0]       samples;
    logic [DIM_W-1:0] h_blk;
    logic [DIM_W-1:0] w_blk;
    logic [2:0]       h_rem;
    logic [2:0]       w_rem;
    logic [DIM_W-1:0] r_add;
    logic [DIM_W-1:0] c_add;

    low_d = (bit_depth_i == DEPTH_1) || (bit_depth_i == DEPTH_2) ||
            (bit_depth_i == DEPTH_4);
    hi_d  = (bit_depth_i == DEPTH_8) || (bit_depth_i == DEPTH_16);
    samples = 3'd0;
    ok_d    = 1'b0;
    unique case (color_type_i)
      CT_GRAY: begin
        samples = 3'd1;
        ok_d    = low_d || hi_d;
      end
      CT_RGB: begin
        samples = 3'd3;
        ok_d    = hi_d;
      end
      CT_INDEXED: begin
        samples = 3'd1;
        ok_d    = low_d || (bit_depth_i == DEPTH_8);
      end
      CT_GRAY_ALPHA: begin
        samples = 3'd2;
        ok_d    = hi_d;
      end
      CT_RGBA: begin
        samples = 3'd4;
        ok_d    = hi_d;
      end
      default: begin
        samples = 3'd0;
        ok_d    = 1'b0;
      end
    endcase
    if (width_i == '0 || height_i == '0) ok_d = 1'b0;
    if (bit_depth_i < DEPTH_8 && interlace_method_i != ILACE_NONE) ok_d = 1'b0;
    if (compression_method_i != COMP_DEFLATE || filter_method_i != FILT_ADAPTIVE) begin
      ok_d = 1'b0;
    end
    if (interlace_method_i > ILACE_ADAM7) ok_d = 1'b0;

    bpp_d = ok_d ? (BPP_W'(samples) * BPP_W'(bit_depth_i[4:0])) : '0;

    h_blk = height_i >> 3;
    w_blk = width_i >> 3;
    h_rem = height_i[2:0];
    w_rem = width_i[2:0];
    for (int p = 0; p < NUM_PASSES; p++) begin
      r_add = (h_rem == 3'd0) ? '0 : DIM_W'(ROW_TAB[p][h_rem]);
      c_add = (w_rem == 3'd0) ? '0 : DIM_W'(COL_TAB[p][w_rem]);
      if (interlace_method_i == ILACE_ADAM7) begin
        lines_d[p] = DIM_W'(h_blk * DIM_W'(ROW_TAB[p][0])) + r_add;
        pix_d[p]   = DIM_W'(w_blk * DIM_W'(COL_TAB[p][0])) + c_add;
      end else begin
        lines_d[p] = (p == 0) ? height_i : '0;
        pix_d[p]   = (p == 0) ? width_i : '0;
      end
      // Drop empty passes and invalid headers by zeroing the row count
      if (!ok_d || lines_d[p] == '0 || pix_d[p] == '0) lines_d[p] = '0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Carry the check flag and bits per pixel along the pipe
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ok_q[0]  <= ok_d;
      bpp_q[0] <= bpp_d;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        ok_q[k]  <= ok_q[k-1];
        bpp_q[k] <= bpp_q[k-1];
      end
    end
  end

  // Stage 1: capture pass dimensions
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int p = 0; p < NUM_PASSES; p++) begin
        lines_s1_q[p] <= lines_d[p];
        pix_s1_q[p]   <= pix_d[p];
      end
    end
  end

  // Stage 2: bits per pass row
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int p = 0; p < NUM_PASSES; p++) begin
        lines_s2_q[p] <= lines_s1_q[p];
        prod_s2_q[p]  <= PROD_W'(pix_s1_q[p]) * PROD_W'(bpp_q[0]);
      end
    end
  end

  // Stage 3: round up to bytes and add the filter byte
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int p = 0; p < NUM_PASSES; p++) begin
        lines_s3_q[p] <= lines_s2_q[p];
        rb_s3_q[p]    <= RB_W'((prod_s2_q[p] + PROD_W'(7)) >> 3) + RB_W'(1);
      end
    end
  end

  // Stage 4: rows times row bytes as two partial products
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int p = 0; p < NUM_PASSES; p++) begin
        plo_s4_q[p] <= PLO_W'(lines_s3_q[p]) * PLO_W'(rb_s3_q[p][LO_W-1:0]);
        phi_s4_q[p] <= PHI_W'(lines_s3_q[p]) * PHI_W'(rb_s3_q[p][RB_W-1:LO_W]);
      end
    end
  end

  // Stage 5: combine partial products, widen to the result width
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int p = 0; p < NUM_PASSES; p++) begin
        term_s5_q[p] <= RAW_W'(TERM_W'(plo_s4_q[p]) + (TERM_W'(phi_s4_q[p]) << LO_W));
      end
    end
  end

  // Stage 6: first level of the pass sum
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      part_s6_q[0] <= term_s5_q[0] + term_s5_q[1];
      part_s6_q[1] <= term_s5_q[2] + term_s5_q[3];
      part_s6_q[2] <= term_s5_q[4] + term_s5_q[5];
      part_s6_q[3] <= term_s5_q[6];
    end
  end

  // Stage 7: final sum into the output register
  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      raw_s7_q <= (part_s6_q[0] + part_s6_q[1]) + (part_s6_q[2] + part_s6_q[3]);
    end
  end

  assign out_valid_o      = vld_q[NUM_STAGES-1];
  assign header_ok_o      = ok_q[NUM_STAGES-1];
  assign bits_per_pixel_o = bpp_q[NUM_STAGES-1];
  assign raw_bytes_o      = raw_s7_q;

  // A rejected header reports nothing but zeros
  a_bad_header_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !header_ok_o |-> bits_per_pixel_o == '0 && raw_bytes_o == '0)
    else $error("rejected header with nonzero result");

  // An accepted header always has pixels and bytes
  a_good_header_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_ok_o |-> bits_per_pixel_o != '0 && raw_bytes_o != '0)
    else $error("accepted header with zero result");

  // Input stalls only when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld_q == '1 && out_stall_i)
    else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire

[bench/tb_png_raw_image_size_top.sv]
// Testbench for the PNG header checker and raw image size block: directed and random headers.
`default_nettype none

module tb_png_raw_image_size_top;
  import pngrs_pkg::*;

  localparam int DIM_W        = 24;
  localparam int RANDOM_HDRS  = 1626;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_PAIRS    = 15;

  // Adam7 pass geometry: first row or column and stride per pass
  localparam int ROW_START [NUM_PASSES] = '{0, 0, 4, 0, 2, 0, 1};
  localparam int ROW_STEP  [NUM_PASSES] = '{8, 8, 8, 4, 4, 2, 2};
  localparam int COL_START [NUM_PASSES] = '{0, 4, 0, 2, 0, 1, 0};
  localparam int COL_STEP  [NUM_PASSES] = '{8, 8, 4, 4, 2, 2, 1};

  // Legal color type and bit depth pairs
  localparam logic [FIELD_W-1:0] PAIR_CT [NUM_PAIRS] = '{
    CT_GRAY, CT_GRAY, CT_GRAY, CT_GRAY, CT_GRAY,
    CT_INDEXED, CT_INDEXED, CT_INDEXED, CT_INDEXED,
    CT_RGB, CT_RGB, CT_GRAY_ALPHA, CT_GRAY_ALPHA, CT_RGBA, CT_RGBA
  };
  localparam logic [FIELD_W-1:0] PAIR_DEPTH [NUM_PAIRS] = '{
    DEPTH_1, DEPTH_2, DEPTH_4, DEPTH_8, DEPTH_16,
    DEPTH_1, DEPTH_2, DEPTH_4, DEPTH_8,
    DEPTH_8, DEPTH_16, DEPTH_8, DEPTH_16, DEPTH_8, DEPTH_16
  };

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [FIELD_W-1:0] depth;
    logic [FIELD_W-1:0] ctype;
    logic [FIELD_W-1:0] comp;
    logic [FIELD_W-1:0] filt;
    logic [FIELD_W-1:0] ilace;
  } png_header_t;

  typedef struct packed {
    logic             ok;
    logic [BPP_W-1:0] bpp;
    logic [RAW_W-1:0] raw;
  } size_result_t;

  // Holds predicted sizes in acceptance order and checks output beats against them
  class raw_size_scoreboard;
    size_result_t pending_sizes[$];
    int           mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Count of rows (or columns) that fall into a pass out of n
    function logic [63:0] pass_span(logic [63:0] n, int first, int stride);
      if (n <= 64'(first)) return 64'd0;
      return (n - 64'(first) + 64'(stride) - 64'd1) / 64'(stride);
    endfunction

    function logic [63:0] line_bytes(logic [63:0] pixels, logic [63:0] bpp);
      return ((pixels * bpp + 64'd7) >> 3) + 64'd1;
    endfunction

    function size_result_t predict_raw_size(png_header_t h);
      size_result_t r;
      logic [63:0]  bpp, total, lines, pix;
      int           samples;
      bit           ok, low, hi;
      r       = '0;
      samples = 0;
      total   = 64'd0;
      low     = (h.depth == DEPTH_1) || (h.depth == DEPTH_2) || (h.depth == DEPTH_4);
      hi      = (h.depth == DEPTH_8) || (h.depth == DEPTH_16);
      case (h.ctype)
        CT_GRAY: begin
          samples = 1;
          ok      = low || hi;
        end
        CT_RGB: begin
          samples = 3;
          ok      = hi;
        end
        CT_INDEXED: begin
          samples = 1;
          ok      = low || (h.depth == DEPTH_8);
        end
        CT_GRAY_ALPHA: begin
          samples = 2;
          ok      = hi;
        end
        CT_RGBA: begin
          samples = 4;
          ok      = hi;
        end
        default: ok = 1'b0;
      endcase
      if (h.width == '0 || h.height == '0) ok = 1'b0;
      if (h.depth < DEPTH_8 && h.ilace != ILACE_NONE) ok = 1'b0;
      if (h.comp != COMP_DEFLATE || h.filt != FILT_ADAPTIVE) ok = 1'b0;
      if (h.ilace > ILACE_ADAM7) ok = 1'b0;
      if (!ok) return r;
      bpp = 64'(samples) * 64'(h.depth);
      if (h.ilace == ILACE_NONE) begin
        total = 64'(h.height) * line_bytes(64'(h.width), bpp);
      end else begin
        // Sum each nonempty Adam7 pass
        for (int p = 0; p < NUM_PASSES; p++) begin
          lines = pass_span(64'(h.height), ROW_START[p], ROW_STEP[p]);
          pix   = pass_span(64'(h.width), COL_START[p], COL_STEP[p]);
          if (lines != 0 && pix != 0) total += lines * line_bytes(pix, bpp);
        end
      end
      r.ok  = 1'b1;
      r.bpp = bpp[BPP_W-1:0];
      r.raw = total[RAW_W-1:0];
      return r;
    endfunction

    function void note_header(png_header_t h);
      pending_sizes.push_back(predict_raw_size(h));
    endfunction

    function void check_result(size_result_t got);
      size_result_t want;
      if (pending_sizes.size() == 0) begin
        report($sformatf("unexpected beat: ok=%0d bpp=%0d raw=%0d", got.ok, got.bpp, got.raw));
        return;
      end
      want = pending_sizes.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("header_ok: expected %0d, got %0d", want.ok, got.ok));
      if (got.bpp !== want.bpp)
        report($sformatf("bits_per_pixel: expected %0d, got %0d", want.bpp, got.bpp));
      if (got.raw !== want.raw)
        report($sformatf("raw_bytes: expected %0d, got %0d", want.raw, got.raw));
    endfunction

    function void flush_leftovers();
      while (pending_sizes.size() > 0) begin
        report($sformatf("missing beat: expected raw=%0d", pending_sizes[0].raw));
        void'(pending_sizes.pop_front());
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [DIM_W-1:0]     width_i;
  logic [DIM_W-1:0]     height_i;
  logic [FIELD_W-1:0]   bit_depth_i;
  logic [FIELD_W-1:0]   color_type_i;
  logic [FIELD_W-1:0]   compression_method_i;
  logic [FIELD_W-1:0]   filter_method_i;
  logic [FIELD_W-1:0]   interlace_method_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 header_ok_o;
  logic [BPP_W-1:0]     bits_per_pixel_o;
  logic [RAW_W-1:0]     raw_bytes_o;

  raw_size_scoreboard   sb = new();
  int                   sent_count = 0;
  int                   cycle_no = 0;
  int                   quiet_cycles = 0;
  size_result_t         seen;

  png_raw_image_size_top #(
    .IMAGE_DIM_BITS(DIM_W)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .width_i              (width_i),
    .height_i             (height_i),
    .bit_depth_i          (bit_depth_i),
    .color_type_i         (color_type_i),
    .compression_method_i (compression_method_i),
    .filter_method_i      (filter_method_i),
    .interlace_method_i   (interlace_method_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .header_ok_o          (header_ok_o),
    .bits_per_pixel_o     (bits_per_pixel_o),
    .raw_bytes_o          (raw_bytes_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic png_header_t mk_header(int unsigned w, int unsigned h,
                                            logic [FIELD_W-1:0] depth,
                                            logic [FIELD_W-1:0] ctype,
                                            logic [FIELD_W-1:0] comp,
                                            logic [FIELD_W-1:0] filt,
                                            logic [FIELD_W-1:0] ilace);
    png_header_t hd;
    hd.width  = w[DIM_W-1:0];
    hd.height = h[DIM_W-1:0];
    hd.depth  = depth;
    hd.ctype  = ctype;
    hd.comp   = comp;
    hd.filt   = filt;
    hd.ilace  = ilace;
    return hd;
  endfunction

  // Mostly small images, some medium, a few across the full range
  function automatic logic [DIM_W-1:0] rand_dim();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return DIM_W'($urandom_range(1, 64));
    if (pick < 95) return DIM_W'($urandom_range(1, 4096));
    return DIM_W'($urandom_range(1, (1 << DIM_W) - 1));
  endfunction

  // Well-formed headers most of the time, then single-field breakage and raw noise
  function automatic png_header_t rand_header();
    png_header_t hd;
    int unsigned kind, pair;
    kind       = $urandom_range(0, 99);
    pair       = $urandom_range(0, NUM_PAIRS - 1);
    hd.width   = rand_dim();
    hd.height  = rand_dim();
    hd.depth   = PAIR_DEPTH[pair];
    hd.ctype   = PAIR_CT[pair];
    hd.comp    = COMP_DEFLATE;
    hd.filt    = FILT_ADAPTIVE;
    hd.ilace   = $urandom_range(0, 1) ? ILACE_ADAM7 : ILACE_NONE;
    if (hd.depth < DEPTH_8 && $urandom_range(0, 7) != 0) hd.ilace = ILACE_NONE;
    if (kind >= 70 && kind < 85) begin
      case ($urandom_range(0, 6))
        0: hd.width = '0;
        1: hd.height = '0;
        2: hd.depth = FIELD_W'($urandom);
        3: hd.ctype = FIELD_W'($urandom);
        4: hd.comp = FIELD_W'($urandom_range(1, 255));
        5: hd.filt = FIELD_W'($urandom_range(1, 255));
        default: hd.ilace = FIELD_W'($urandom_range(2, 255));
      endcase
    end else if (kind >= 85) begin
      hd.width  = DIM_W'($urandom);
      hd.height = DIM_W'($urandom);
      hd.depth  = FIELD_W'($urandom);
      hd.ctype  = FIELD_W'($urandom);
      hd.comp   = FIELD_W'($urandom);
      hd.filt   = FIELD_W'($urandom);
      hd.ilace  = FIELD_W'($urandom);
    end
    return hd;
  endfunction

  // Present one header, idling first at random, and hold it until accepted
  task automatic send_header(input png_header_t hd);
    while (!(sent_count >= 700 && sent_count < 1000) && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    width_i              <= hd.width;
    height_i             <= hd.height;
    bit_depth_i          <= hd.depth;
    color_type_i         <= hd.ctype;
    compression_method_i <= hd.comp;
    filter_method_i      <= hd.filt;
    interlace_method_i   <= hd.ilace;
    in_valid_i           <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_header(hd);
    sent_count++;
  endtask

  // Check output beats and stall the output side at random
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.ok  = header_ok_o;
      seen.bpp = bits_per_pixel_o;
      seen.raw = raw_bytes_o;
      sb.check_result(seen);
    end
    if (cycle_no >= 800 && cycle_no < 1400) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 24);
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_png_raw_image_size_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    in_valid_i           <= 1'b0;
    width_i              <= '0;
    height_i             <= '0;
    bit_depth_i          <= '0;
    color_type_i         <= '0;
    compression_method_i <= '0;
    filter_method_i      <= '0;
    interlace_method_i   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every legal pair, with tiny, empty-pass and full-size images
    send_header(mk_header(1, 1, DEPTH_1, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(3, 5, DEPTH_2, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(7, 2, DEPTH_4, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(1, 1, DEPTH_8, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_ADAM7));
    send_header(mk_header(9, 9, DEPTH_16, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_ADAM7));
    send_header(mk_header(17, 3, DEPTH_1, CT_INDEXED, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(5, 4, DEPTH_2, CT_INDEXED, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(3, 8, DEPTH_4, CT_INDEXED, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(6, 7, DEPTH_8, CT_INDEXED, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_ADAM7));
    send_header(mk_header(2, 3, DEPTH_8, CT_RGB, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_ADAM7));
    send_header(mk_header(8, 1, DEPTH_16, CT_RGB, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(4, 4, DEPTH_8, CT_GRAY_ALPHA, COMP_DEFLATE, FILT_ADAPTIVE,
                          ILACE_NONE));
    send_header(mk_header(5, 6, DEPTH_16, CT_GRAY_ALPHA, COMP_DEFLATE, FILT_ADAPTIVE,
                          ILACE_ADAM7));
    send_header(mk_header(13, 11, DEPTH_8, CT_RGBA, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_ADAM7));
    send_header(mk_header((1 << DIM_W) - 1, (1 << DIM_W) - 1, DEPTH_16, CT_RGBA, COMP_DEFLATE,
                          FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header((1 << DIM_W) - 1, (1 << DIM_W) - 1, DEPTH_16, CT_RGBA, COMP_DEFLATE,
                          FILT_ADAPTIVE, ILACE_ADAM7));

    // Rejected headers: empty size, bad pair, bad methods, low depth interlaced
    send_header(mk_header(0, 10, DEPTH_8, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(10, 0, DEPTH_8, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(4, 4, DEPTH_16, CT_INDEXED, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(4, 4, DEPTH_8, 8'd1, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(4, 4, DEPTH_8, CT_RGB, 8'd1, FILT_ADAPTIVE, ILACE_NONE));
    send_header(mk_header(4, 4, DEPTH_8, CT_RGB, COMP_DEFLATE, 8'd255, ILACE_NONE));
    send_header(mk_header(4, 4, DEPTH_8, CT_RGB, COMP_DEFLATE, FILT_ADAPTIVE, 8'd2));
    send_header(mk_header(4, 4, DEPTH_4, CT_GRAY, COMP_DEFLATE, FILT_ADAPTIVE, ILACE_ADAM7));

    // Random headers
    repeat (RANDOM_HDRS) send_header(rand_header());
    in_valid_i <= 1'b0;

    // Drain the pipeline, then watch for stray beats
    while (sb.pending_sizes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("tb_png_raw_image_size_top: done, clean");
    end else begin
      $display("tb_png_raw_image_size_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
